// ===== rtl/core/rtbf_pkg.sv =====
// Package with sizes, register indexes and reset values of the row transition band finder.
package rtbf_pkg;

    localparam int MAX_ROWS = 2048;
    localparam int MAX_COLS = 4096;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int CNT_W   = $clog2(MAX_COLS);
    localparam int LEN_W   = ROW_W + 1;
    localparam int SUM_W   = ROW_W + 2;
    localparam int PIX_W   = 8;
    localparam int MARG_W  = 8;
    localparam int CFG_W   = 12;
    localparam int CIDX_W  = 2;

    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_ROWS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COLS - 1);

    typedef enum logic [CIDX_W-1:0] {
        REG_MIN_TRANS = 2'd0,
        REG_MAX_TRANS = 2'd1,
        REG_MARGIN    = 2'd2
    } t_cfg_index;

    localparam logic [CNT_W-1:0]  RST_MIN_TRANS = CNT_W'(16);
    localparam logic [CNT_W-1:0]  RST_MAX_TRANS = CNT_W'(40);
    localparam logic [MARG_W-1:0] RST_MARGIN    = MARG_W'(15);

endpackage

// ===== rtl/core/row_transition_band_finder_top.sv =====
// Top level of the row transition band finder: row scan, run tracking and band output.
//
//  channel | direction | beat carries                           | handshake
//  --------+-----------+----------------------------------------+----------------------
//  in      | input     | pixel, row_end, frame_end              | i_in_valid/o_in_stall
//  out     | output    | band_first_row, band_last_row, found   | o_out_valid/i_out_stall
//  cfg     | input     | register index, write data             | i_cfg_we
//
// One pixel beat is taken every clock while o_in_stall is low. A frame-end beat folds the
// last row into the run tracking and is snapshot into the snapshot register; the band is
// then widened and clamped into the output register. The input stalls only when both
// the snapshot and output registers hold undelivered results. Reset is synchronous and
// active low; it restores the register defaults and clears all frame state.
module row_transition_band_finder_top
    import rtbf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [PIX_W-1:0]  i_pixel,
    input  logic              i_row_end,
    input  logic              i_frame_end,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ROW_W-1:0]  o_band_first_row,
    output logic [ROW_W-1:0]  o_band_last_row,
    output logic              o_band_found
);

    // Configuration registers.
    logic [CNT_W-1:0]  r_min_trans;
    logic [CNT_W-1:0]  r_max_trans;
    logic [MARG_W-1:0] r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_trans <= RST_MIN_TRANS;
            r_max_trans <= RST_MAX_TRANS;
            r_margin    <= RST_MARGIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MIN_TRANS: r_min_trans <= i_cfg_data[CNT_W-1:0];
                REG_MAX_TRANS: r_max_trans <= i_cfg_data[CNT_W-1:0];
                REG_MARGIN:    r_margin    <= i_cfg_data[MARG_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame state.
    logic [PIX_W-1:0] r_prev_pixel;
    logic             r_row_start;
    logic [CNT_W-1:0] r_count;
    logic [ROW_W-1:0] r_row_index;
    logic             r_run_open;
    logic [ROW_W-1:0] r_run_first;
    logic [ROW_W-1:0] r_best_first;
    logic [LEN_W-1:0] r_best_len;

    // Snapshot of a finished frame and the output register.
    logic             r_snap_valid;
    logic [ROW_W-1:0] r_snap_first;
    logic [LEN_W-1:0] r_snap_len;
    logic [ROW_W-1:0] r_snap_row;
    logic [MARG_W-1:0] r_snap_margin;

    logic             r_out_valid;
    logic [ROW_W-1:0] r_out_first;
    logic [ROW_W-1:0] r_out_last;
    logic             r_out_found;

    logic out_free;
    logic snap_move;
    logic in_accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign snap_move  = r_snap_valid && out_free;
    assign o_in_stall = r_snap_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Per-beat scan logic.
    logic [CNT_W-1:0] n_count;
    logic             eol;
    logic             qual;
    logic [ROW_W-1:0] n_run_first;
    logic             offer;
    logic [LEN_W-1:0] offer_len;
    logic [ROW_W-1:0] n_best_first;
    logic [LEN_W-1:0] n_best_len;

    always_comb begin
        if (r_row_start) begin
            n_count = '0;
        end else if (i_pixel != r_prev_pixel && r_count != CNT_MAX) begin
            n_count = r_count + CNT_W'(1);
        end else begin
            n_count = r_count;
        end

        eol  = i_row_end || i_frame_end;
        qual = (n_count >= r_min_trans) && (n_count <= r_max_trans);
        n_run_first = r_run_open ? r_run_first : r_row_index;

        // A run closes either on a failing row (it ended one row earlier) or, when the
        // last row still qualifies, at the frame's final row. The two never coincide.
        offer = eol && ((!qual && r_run_open) || (qual && i_frame_end));
        if (qual) begin
            offer_len = LEN_W'(r_row_index) - LEN_W'(n_run_first) + LEN_W'(1);
        end else begin
            offer_len = LEN_W'(r_row_index) - LEN_W'(r_run_first);
        end

        if (offer && offer_len > r_best_len) begin
            n_best_len   = offer_len;
            n_best_first = qual ? n_run_first : r_run_first;
        end else begin
            n_best_len   = r_best_len;
            n_best_first = r_best_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pixel <= '0;
            r_row_start  <= 1'b1;
            r_count      <= '0;
            r_row_index  <= '0;
            r_run_open   <= 1'b0;
            r_run_first  <= '0;
            r_best_first <= '0;
            r_best_len   <= '0;
        end else if (in_accept) begin
            if (i_frame_end) begin
                r_prev_pixel <= '0;
                r_row_start  <= 1'b1;
                r_count      <= '0;
                r_row_index  <= '0;
                r_run_open   <= 1'b0;
                r_run_first  <= '0;
                r_best_first <= '0;
                r_best_len   <= '0;
            end else if (eol) begin
                r_prev_pixel <= i_pixel;
                r_row_start  <= 1'b1;
                r_count      <= '0;
                r_run_open   <= qual;
                r_run_first  <= qual ? n_run_first : r_run_first;
                r_best_first <= n_best_first;
                r_best_len   <= n_best_len;
                if (r_row_index != ROW_MAX) begin
                    r_row_index <= r_row_index + ROW_W'(1);
                end
            end else begin
                r_prev_pixel <= i_pixel;
                r_row_start  <= 1'b0;
                r_count      <= n_count;
            end
        end
    end

    // Snapshot stage: holds the best run of a finished frame until the output takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (in_accept && i_frame_end) begin
            r_snap_valid <= 1'b1;
        end else if (snap_move) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_frame_end) begin
            r_snap_first  <= n_best_first;
            r_snap_len    <= n_best_len;
            r_snap_row    <= r_row_index;
            r_snap_margin <= r_margin;
        end
    end

    // Band widening and clamping.
    logic             found;
    logic [SUM_W-1:0] last_sum;
    logic [ROW_W-1:0] n_out_first;
    logic [ROW_W-1:0] n_out_last;

    always_comb begin
        found    = r_snap_len != '0;
        last_sum = SUM_W'(r_snap_first) + SUM_W'(r_snap_len) + SUM_W'(r_snap_margin)
                   - SUM_W'(1);
        if (!found) begin
            n_out_first = '0;
            n_out_last  = '0;
        end else begin
            if (ROW_W'(r_snap_margin) <= r_snap_first) begin
                n_out_first = r_snap_first - ROW_W'(r_snap_margin);
            end else begin
                n_out_first = '0;
            end
            if (last_sum > SUM_W'(r_snap_row)) begin
                n_out_last = r_snap_row;
            end else begin
                n_out_last = last_sum[ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (snap_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_move) begin
            r_out_first <= n_out_first;
            r_out_last  <= n_out_last;
            r_out_found <= found;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_band_first_row = r_out_first;
    assign o_band_last_row  = r_out_last;
    assign o_band_found     = r_out_found;

endmodule
